// ===== rtl/core/mesh_adjacency_builder_core_defines.svh =====
// Assertion macros for the mesh adjacency core.
// Each macro takes a label, the clock, the reset and the checked expressions.
`ifndef MESH_ADJACENCY_BUILDER_CORE_DEFINES_SVH
`define MESH_ADJACENCY_BUILDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// ante true at an edge requires cons true at the same edge
`define MAB_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mab: same-cycle check failed");

// ante true at an edge requires cons true at the next edge
`define MAB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mab: next-cycle check failed");

`else

`define MAB_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define MAB_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/mab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mab_pkg;

   // Fixed field widths of the transaction payloads
   localparam int CMD_W     = 2;
   localparam int VERT_W    = 10;
   localparam int SLOT_W    = 5;
   localparam int TOTAL_W   = 5;
   localparam int STATUS_W  = 2;
   localparam int VCOUNT_W  = 11;

   // Defaults for the storage parameters
   localparam int MAX_VERTICES_DEF  = 1024;
   localparam int MAX_NEIGHBORS_DEF = 24;

   localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RESET = 11'd1024;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_COUNT = 2'd2,
      CMD_ENTRY = 2'd3
   } mab_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_SLOT     = 2'd3
   } mab_status_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [VERT_W-1:0] vert_a;
      logic [VERT_W-1:0] vert_b;
      logic [VERT_W-1:0] vert_c;
      logic [SLOT_W-1:0] slot;
   } mab_req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0]  neighbor_total;
      logic [VERT_W-1:0]   neighbor_index;
      logic [STATUS_W-1:0] status;
   } mab_rsp_type;

   // Memory port strobes from the sequencer to the storage
   typedef struct packed {
      logic cnt_rd;
      logic cnt_wr;
      logic list_rd;
      logic list_wr;
   } mab_mem_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/mab_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mab_store
   import mab_pkg::*;
#(
   parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
   parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
   localparam int VIDX_W  = $clog2(MAX_VERTICES),
   localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1),
   localparam int LIST_AW = $clog2(MAX_VERTICES * MAX_NEIGHBORS)
) (
   input  wire logic            clock,
   input  wire mab_mem_ctl_type mem_ctl,
   input  wire logic [VIDX_W-1:0]  cnt_addr,
   input  wire logic [CNT_W-1:0]   cnt_wdata,
   output logic      [CNT_W-1:0]   cnt_rdata,
   input  wire logic [LIST_AW-1:0] list_addr,
   input  wire logic [VERT_W-1:0]  list_wdata,
   output logic      [VERT_W-1:0]  list_rdata
);

   logic [CNT_W-1:0]  cnt_mem  [MAX_VERTICES];
   logic [VERT_W-1:0] list_mem [MAX_VERTICES * MAX_NEIGHBORS];

   // Per-vertex neighbor counts, registered read
   always_ff @(posedge clock) begin
      if (mem_ctl.cnt_wr) begin
         cnt_mem[cnt_addr] <= cnt_wdata;
      end
      if (mem_ctl.cnt_rd) begin
         cnt_rdata <= cnt_mem[cnt_addr];
      end
   end

   // Neighbor lists, one row of MAX_NEIGHBORS per vertex, registered read
   always_ff @(posedge clock) begin
      if (mem_ctl.list_wr) begin
         list_mem[list_addr] <= list_wdata;
      end
      if (mem_ctl.list_rd) begin
         list_rdata <= list_mem[list_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mab_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mab_seq
   import mab_pkg::*;
#(
   parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
   parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
   localparam int VIDX_W  = $clog2(MAX_VERTICES),
   localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1),
   localparam int LIST_AW = $clog2(MAX_VERTICES * MAX_NEIGHBORS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire mab_req_type       req,
   input  wire logic [VCOUNT_W-1:0] vertex_count,
   input  wire logic              rsp_free,
   output logic                   ready,
   output logic                   done,
   output mab_rsp_type            rsp,
   output mab_mem_ctl_type        mem_ctl,
   output logic [VIDX_W-1:0]      cnt_addr,
   output logic [CNT_W-1:0]       cnt_wdata,
   input  wire logic [CNT_W-1:0]  cnt_rdata,
   output logic [LIST_AW-1:0]     list_addr,
   output logic [VERT_W-1:0]      list_wdata,
   input  wire logic [VERT_W-1:0] list_rdata
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CNT_RD,
      S_CNT_WAIT,
      S_SCAN,
      S_TOT_RD,
      S_TOT_WAIT,
      S_ENT_RD,
      S_ENT_WAIT,
      S_DONE
   } state_type;

   localparam logic [2:0]        INS_LAST = 3'd5;
   localparam logic [VIDX_W-1:0] VERT_LAST = VIDX_W'(MAX_VERTICES - 1);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_NEIGHBORS);

   // Result of a rejected vertex index
   localparam mab_rsp_type RSP_RANGE = '{neighbor_total: '0, neighbor_index: '0,
                                         status: ST_RANGE};

   state_type            state_ff;
   logic [CMD_W-1:0]     cmd_ff;
   logic [VIDX_W-1:0]    va_ff, vb_ff, vc_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [2:0]           ins_ff;
   logic [CNT_W-1:0]     k_ff, n_ff;
   logic [LIST_AW-1:0]   base_ff, base_in;
   logic                 pend_ff, drop_ff;
   logic [VIDX_W-1:0]    clr_idx_ff;
   logic                 clr_rsp_ff;
   mab_rsp_type          rsp_ff;

   logic [VIDX_W-1:0]    owner, value, base_vert;
   logic                 hit;
   logic                 ok_a, ok_b, ok_c;

   // Index is usable when below both vertex_count and the table depth
   assign ok_a = (VCOUNT_W'(req.vert_a) < vertex_count) && (32'(req.vert_a) < MAX_VERTICES);
   assign ok_b = (VCOUNT_W'(req.vert_b) < vertex_count) && (32'(req.vert_b) < MAX_VERTICES);
   assign ok_c = (VCOUNT_W'(req.vert_c) < vertex_count) && (32'(req.vert_c) < MAX_VERTICES);

   // Six inserts per triangle: (a,b) (a,c) (b,a) (b,c) (c,a) (c,b)
   always_comb begin
      case (ins_ff)
         3'd0: begin owner = va_ff; value = vb_ff; end
         3'd1: begin owner = va_ff; value = vc_ff; end
         3'd2: begin owner = vb_ff; value = va_ff; end
         3'd3: begin owner = vb_ff; value = vc_ff; end
         3'd4: begin owner = vc_ff; value = va_ff; end
         default: begin owner = vc_ff; value = vb_ff; end
      endcase
   end

   // Shared compare unit: the stored entry read last cycle vs. the insert value
   assign hit = pend_ff && (list_rdata == VERT_W'(value));

   // Row base of a vertex in the list memory, registered before use
   assign base_vert = (state_ff == S_TOT_RD) ? va_ff : owner;
   assign base_in   = LIST_AW'(base_vert) * LIST_AW'(MAX_NEIGHBORS);

   assign ready = (state_ff == S_IDLE);
   assign done  = (state_ff == S_DONE);
   assign rsp   = rsp_ff;

   // Memory port control
   always_comb begin
      mem_ctl    = '0;
      cnt_addr   = owner;
      cnt_wdata  = '0;
      list_addr  = base_ff + LIST_AW'(k_ff);
      list_wdata = VERT_W'(value);
      case (state_ff)
         S_CLEAR: begin
            mem_ctl.cnt_wr = 1'b1;
            cnt_addr       = clr_idx_ff;
         end
         S_CNT_RD: begin
            mem_ctl.cnt_rd = 1'b1;
         end
         S_SCAN: begin
            if (!hit) begin
               if (k_ff < n_ff) begin
                  mem_ctl.list_rd = 1'b1;
               end else if (n_ff < CNT_MAX) begin
                  mem_ctl.list_wr = 1'b1;
                  list_addr       = base_ff + LIST_AW'(n_ff);
                  mem_ctl.cnt_wr  = 1'b1;
                  cnt_wdata       = n_ff + CNT_W'(1);
               end
            end
         end
         S_TOT_RD: begin
            mem_ctl.cnt_rd = 1'b1;
            cnt_addr       = va_ff;
         end
         S_ENT_RD: begin
            mem_ctl.list_rd = 1'b1;
            list_addr       = base_ff + LIST_AW'(slot_ff);
         end
         default: begin
         end
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_idx_ff <= '0;
         clr_rsp_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + VIDX_W'(1);
               if (clr_idx_ff == VERT_LAST) begin
                  state_ff <= clr_rsp_ff ? S_DONE : S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff  <= req.command;
                  va_ff   <= VIDX_W'(req.vert_a);
                  vb_ff   <= VIDX_W'(req.vert_b);
                  vc_ff   <= VIDX_W'(req.vert_c);
                  slot_ff <= req.slot;
                  ins_ff  <= '0;
                  drop_ff <= 1'b0;
                  pend_ff <= 1'b0;
                  case (req.command)
                     CMD_CLEAR: begin
                        rsp_ff     <= '0;
                        clr_idx_ff <= '0;
                        clr_rsp_ff <= 1'b1;
                        state_ff   <= S_CLEAR;
                     end
                     CMD_ADD: begin
                        if (ok_a && ok_b && ok_c) begin
                           rsp_ff   <= '0;
                           state_ff <= S_CNT_RD;
                        end else begin
                           rsp_ff   <= RSP_RANGE;
                           state_ff <= S_DONE;
                        end
                     end
                     default: begin
                        if (ok_a) begin
                           rsp_ff   <= '0;
                           state_ff <= S_TOT_RD;
                        end else begin
                           rsp_ff   <= RSP_RANGE;
                           state_ff <= S_DONE;
                        end
                     end
                  endcase
               end
            end
            S_CNT_RD: begin
               base_ff  <= base_in;
               state_ff <= S_CNT_WAIT;
            end
            S_CNT_WAIT: begin
               n_ff     <= cnt_rdata;
               k_ff     <= '0;
               pend_ff  <= 1'b0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (!hit && (k_ff < n_ff)) begin
                  // keep scanning, one stored entry per cycle
                  pend_ff <= 1'b1;
                  k_ff    <= k_ff + CNT_W'(1);
               end else begin
                  // duplicate found, or scan finished (append or drop)
                  if (!hit && (n_ff >= CNT_MAX)) begin
                     drop_ff <= 1'b1;
                  end
                  pend_ff <= 1'b0;
                  if (ins_ff == INS_LAST) begin
                     state_ff <= S_TOT_RD;
                  end else begin
                     ins_ff   <= ins_ff + 3'd1;
                     state_ff <= S_CNT_RD;
                  end
               end
            end
            S_TOT_RD: begin
               base_ff  <= base_in;
               state_ff <= S_TOT_WAIT;
            end
            S_TOT_WAIT: begin
               rsp_ff.neighbor_total <= TOTAL_W'(cnt_rdata);
               case (cmd_ff)
                  CMD_ADD: begin
                     rsp_ff.status <= drop_ff ? ST_OVERFLOW : ST_OK;
                     state_ff      <= S_DONE;
                  end
                  CMD_ENTRY: begin
                     if ((32'(slot_ff) >= 32'(cnt_rdata)) ||
                         (32'(slot_ff) >= MAX_NEIGHBORS)) begin
                        rsp_ff.status <= ST_SLOT;
                        state_ff      <= S_DONE;
                     end else begin
                        state_ff <= S_ENT_RD;
                     end
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_ENT_RD: begin
               state_ff <= S_ENT_WAIT;
            end
            S_ENT_WAIT: begin
               rsp_ff.neighbor_index <= list_rdata;
               state_ff              <= S_DONE;
            end
            S_DONE: begin
               if (rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mesh_adjacency_builder_core.sv =====
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  mab_req_type (command, corners, slot)
// rsp      out        rsp_valid/rsp_stall  mab_rsp_type (total, index, status)
// csr      in         csr_wr_en            csr_wr_data = vertex_count
//
// One transaction at a time. A count read fetches the vertex's list length; an entry
// read also fetches one stored neighbor. Add triangle makes 6 inserts, each scanning
// up to n stored entries (n = list length, up to MAX_NEIGHBORS) with the single compare unit.
// Clear walks the count memory: one count memory entry zeroed per cycle.
// After reset the same clearing pass runs with req_stall high.
// A finished result waits in the output register; a new transaction is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

`include "mesh_adjacency_builder_core_defines.svh"

module mesh_adjacency_builder_core
   import mab_pkg::*;
#(
   parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
   parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire mab_req_type         req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output mab_rsp_type              rsp_data,
   input  wire logic                csr_wr_en,
   input  wire logic [VCOUNT_W-1:0] csr_wr_data
);

   localparam int VIDX_W  = $clog2(MAX_VERTICES);
   localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);
   localparam int LIST_AW = $clog2(MAX_VERTICES * MAX_NEIGHBORS);

   logic [VCOUNT_W-1:0] vertex_count_ff;
   logic                rsp_valid_ff;
   mab_rsp_type         rsp_data_ff;

   logic                seq_ready, seq_done, rsp_free;
   mab_rsp_type         seq_rsp;
   mab_mem_ctl_type     mem_ctl;
   logic [VIDX_W-1:0]   cnt_addr;
   logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
   logic [LIST_AW-1:0]  list_addr;
   logic [VERT_W-1:0]   list_wdata, list_rdata;

   // Vertex count register
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
      end else if (csr_wr_en) begin
         vertex_count_ff <= csr_wr_data;
      end
   end

   assign req_stall = !seq_ready;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   mab_seq #(
      .MAX_VERTICES  (MAX_VERTICES),
      .MAX_NEIGHBORS (MAX_NEIGHBORS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req          (req_data),
      .vertex_count (vertex_count_ff),
      .rsp_free     (rsp_free),
      .ready        (seq_ready),
      .done         (seq_done),
      .rsp          (seq_rsp),
      .mem_ctl      (mem_ctl),
      .cnt_addr     (cnt_addr),
      .cnt_wdata    (cnt_wdata),
      .cnt_rdata    (cnt_rdata),
      .list_addr    (list_addr),
      .list_wdata   (list_wdata),
      .list_rdata   (list_rdata)
   );

   mab_store #(
      .MAX_VERTICES  (MAX_VERTICES),
      .MAX_NEIGHBORS (MAX_NEIGHBORS)
   ) u_store (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .cnt_addr   (cnt_addr),
      .cnt_wdata  (cnt_wdata),
      .cnt_rdata  (cnt_rdata),
      .list_addr  (list_addr),
      .list_wdata (list_wdata),
      .list_rdata (list_rdata)
   );

   // Output register: loads a finished result once the previous one is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_done && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done && rsp_free) begin
         rsp_data_ff <= seq_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `MAB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `MAB_ASSERT_NEXT(a_result_held, clock, reset, seq_done && !rsp_free, seq_done)
   `MAB_ASSERT_IMPLY(a_count_bound, clock, reset, mem_ctl.cnt_wr, 32'(cnt_wdata) <= MAX_NEIGHBORS)
   `MAB_ASSERT_IMPLY(a_list_with_count, clock, reset, mem_ctl.list_wr, mem_ctl.cnt_wr)

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import mab_pkg::*;

   localparam int NV = MAX_VERTICES_DEF;
   localparam int NN = MAX_NEIGHBORS_DEF;

   // Clock, reset and block inputs, all known from time zero
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   mab_req_type         req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   mab_rsp_type         rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [VCOUNT_W-1:0] csr_wr_data = '0;

   // Shadow copy of the adjacency table and the vertex_count register
   logic [VCOUNT_W-1:0] cfg_vertex_count = VERTEX_COUNT_RESET;
   logic [TOTAL_W-1:0]  shadow_count [NV];
   logic [VERT_W-1:0]   shadow_list  [NV*NN];

   mab_req_type pending_cmds[$];
   mab_rsp_type expected_rsps[$];
   int          errors = 0;

   // Driver and monitor pacing
   int unsigned drv_gap = 0;
   int unsigned drv_draw;
   bit          drv_burst = 1'b0;
   int unsigned mon_left = 0;
   int unsigned mon_draw;
   bit          mon_burst = 1'b0;

   mesh_adjacency_builder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Vertex is usable when below vertex_count, capped at the table size
   function automatic bit vertex_in_use(logic [VERT_W-1:0] v);
      int lim;
      lim = (cfg_vertex_count > NV) ? NV : int'(cfg_vertex_count);
      return int'(v) < lim;
   endfunction

   // Append value to owner's list unless present; returns 1 when full and dropped
   function automatic bit insert_adjacent(logic [VERT_W-1:0] owner, logic [VERT_W-1:0] value);
      int n;
      int base;
      n    = int'(shadow_count[owner]);
      base = int'(owner) * NN;
      for (int k = 0; k < n && k < NN; k++) begin
         if (shadow_list[base + k] == value) return 1'b0;
      end
      if (n >= NN) return 1'b1;
      shadow_list[base + n] = value;
      shadow_count[owner]   = TOTAL_W'(n + 1);
      return 1'b0;
   endfunction

   // Updates the shadow table for one transaction and returns its response
   function automatic mab_rsp_type predict_adjacency(mab_req_type rq);
      mab_rsp_type r;
      bit          drop;
      r    = '0;
      r.status = ST_OK;
      drop = 1'b0;
      case (rq.command)
         CMD_CLEAR: begin
            foreach (shadow_count[i]) shadow_count[i] = '0;
         end
         CMD_ADD: begin
            if (!vertex_in_use(rq.vert_a) || !vertex_in_use(rq.vert_b) ||
                !vertex_in_use(rq.vert_c)) begin
               r.status = ST_RANGE;
            end else begin
               drop |= insert_adjacent(rq.vert_a, rq.vert_b);
               drop |= insert_adjacent(rq.vert_a, rq.vert_c);
               drop |= insert_adjacent(rq.vert_b, rq.vert_a);
               drop |= insert_adjacent(rq.vert_b, rq.vert_c);
               drop |= insert_adjacent(rq.vert_c, rq.vert_a);
               drop |= insert_adjacent(rq.vert_c, rq.vert_b);
               r.neighbor_total = shadow_count[rq.vert_a];
               if (drop) r.status = ST_OVERFLOW;
            end
         end
         default: begin
            if (!vertex_in_use(rq.vert_a)) begin
               r.status = ST_RANGE;
            end else begin
               r.neighbor_total = shadow_count[rq.vert_a];
               if (rq.command == CMD_ENTRY) begin
                  if (rq.slot >= r.neighbor_total || rq.slot >= NN)
                     r.status = ST_SLOT;
                  else
                     r.neighbor_index = shadow_list[int'(rq.vert_a) * NN + int'(rq.slot)];
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic mab_req_type make_cmd(mab_cmd_type cmd, int a, int b, int c, int s);
      mab_req_type rq;
      rq.command = cmd;
      rq.vert_a  = VERT_W'(a);
      rq.vert_b  = VERT_W'(b);
      rq.vert_c  = VERT_W'(c);
      rq.slot    = SLOT_W'(s);
      return rq;
   endfunction

   // Corner choice biased toward a few hub vertices so their lists fill up
   function automatic int pick_vertex();
      int lim;
      int roll;
      lim  = (cfg_vertex_count > NV) ? NV : int'(cfg_vertex_count);
      roll = $urandom_range(0, 99);
      if (lim == 0 || roll < 10) return $urandom_range(0, NV - 1);
      if (roll < 40) return $urandom_range(0, ((lim < 3) ? lim : 3) - 1);
      return $urandom_range(0, lim - 1);
   endfunction

   function automatic mab_req_type random_cmd();
      mab_req_type rq;
      int          roll;
      int          s;
      roll = $urandom_range(0, 239);
      s    = $urandom_range(0, 99);
      if (s < 50)      s = $urandom_range(0, 3);
      else if (s < 85) s = $urandom_range(0, 25);
      else             s = $urandom_range(0, 31);
      rq = make_cmd(CMD_ADD, pick_vertex(), pick_vertex(), pick_vertex(), s);
      if (roll < 2)        rq.command = CMD_CLEAR;
      else if (roll < 122) rq.command = CMD_ADD;
      else if (roll < 158) rq.command = CMD_COUNT;
      else                 rq.command = CMD_ENTRY;
      return rq;
   endfunction

   // Wait until no transaction is queued, in flight or owed a response
   task automatic wait_drained();
      @(negedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_vertex_count(int value);
      wait_drained();
      @(posedge clock);
      csr_wr_en        <= 1'b1;
      csr_wr_data      <= VCOUNT_W'(value);
      cfg_vertex_count  = VCOUNT_W'(value);
      @(posedge clock);
      csr_wr_en        <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_random(int count);
      @(negedge clock);
      repeat (count) pending_cmds.push_back(random_cmd());
   endtask

   // Request driver: presents queued transactions with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         drv_gap   <= 0;
      end else if (req_valid && !req_stall) begin
         expected_rsps.push_back(predict_adjacency(req_data));
         if ($urandom_range(0, 39) == 0) drv_burst = !drv_burst;
         drv_draw = drv_burst ? 0 : $urandom_range(0, 8);
         if (drv_draw == 0 && pending_cmds.size() != 0) begin
            req_data <= pending_cmds.pop_front();
         end else begin
            req_valid <= 1'b0;
            drv_gap   <= drv_draw;
         end
      end else if (!req_valid) begin
         if (drv_gap != 0) begin
            drv_gap <= drv_gap - 1;
         end else if (pending_cmds.size() != 0) begin
            req_data  <= pending_cmds.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Response monitor: checks each accepted response, then stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         mon_left  <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response: total %0d index %0d status %0d",
                   rsp_data.neighbor_total, rsp_data.neighbor_index, rsp_data.status);
            errors++;
         end else begin
            mab_rsp_type exp_rsp;
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.neighbor_total !== exp_rsp.neighbor_total) begin
               $error("neighbor_total: expected %0d, got %0d",
                      exp_rsp.neighbor_total, rsp_data.neighbor_total);
               errors++;
            end
            if (rsp_data.neighbor_index !== exp_rsp.neighbor_index) begin
               $error("neighbor_index: expected %0d, got %0d",
                      exp_rsp.neighbor_index, rsp_data.neighbor_index);
               errors++;
            end
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_data.status);
               errors++;
            end
         end
         if ($urandom_range(0, 39) == 0) mon_burst = !mon_burst;
         mon_draw = mon_burst ? 0 : $urandom_range(0, 8);
         mon_left  <= mon_draw;
         rsp_stall <= (mon_draw != 0);
      end else if (rsp_stall) begin
         if (mon_left <= 1) rsp_stall <= 1'b0;
         mon_left <= mon_left - 1;
      end
   end

   // Stimulus sequence
   initial begin
      foreach (shadow_count[i]) shadow_count[i] = '0;
      foreach (shadow_list[i]) shadow_list[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, self loop, fill vertex 0 to capacity, then overflow
      @(negedge clock);
      pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_COUNT, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_ENTRY, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_ADD, 5, 5, 5, 0));
      pending_cmds.push_back(make_cmd(CMD_ENTRY, 5, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_ADD, 0, 1022, 1023, 31));
      for (int k = 0; k < 11; k++)
         pending_cmds.push_back(make_cmd(CMD_ADD, 0, 2*k + 1, 2*k + 2, 0));
      pending_cmds.push_back(make_cmd(CMD_ADD, 0, 30, 31, 0));
      pending_cmds.push_back(make_cmd(CMD_ENTRY, 0, 0, 0, 23));
      pending_cmds.push_back(make_cmd(CMD_ENTRY, 0, 0, 0, 24));
      pending_cmds.push_back(make_cmd(CMD_ENTRY, 0, 1023, 1023, 31));
      pending_cmds.push_back(make_cmd(CMD_COUNT, 1023, 0, 0, 0));

      // Directed: corners beyond a reduced vertex_count
      write_vertex_count(1000);
      pending_cmds.push_back(make_cmd(CMD_ADD, 0, 1, 1010, 0));
      pending_cmds.push_back(make_cmd(CMD_COUNT, 1023, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_ENTRY, 999, 0, 0, 0));

      // Directed: vertex_count zero rejects every vertex
      write_vertex_count(0);
      pending_cmds.push_back(make_cmd(CMD_ADD, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_COUNT, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_ENTRY, 0, 0, 0, 0));

      // Random phases over several register settings
      write_vertex_count(30);
      queue_random(500);
      write_vertex_count(2047);
      queue_random(300);
      write_vertex_count(3);
      queue_random(250);
      write_vertex_count(1);
      queue_random(150);
      write_vertex_count(25);
      queue_random(350);
      write_vertex_count(1024);
      queue_random(200);
      write_vertex_count(600);
      queue_random(150);

      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #15_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
